// ===== design/bmtk_pkg.sv =====
// Shared types, constants and command/status structs for the bend multipole thin kick unit.
// No dependencies; the top level, bmtk_ctrl, bmtk_datapath and bmtk_mul use this package.
`timescale 1ns / 1ps

package bmtk_pkg;

  // Word format: signed fixed point, FRAC_BITS fraction bits
  localparam int WORD_BITS   = 48;
  localparam int FRAC_BITS   = 32;
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ORDER_BITS  = 4;
  localparam int CIDX_BITS   = 4;

  // Multiplier splits each magnitude into two halves
  localparam int HALF_BITS = (WORD_BITS + 1) / 2;
  localparam int PROD_BITS = 4 * HALF_BITS;
  localparam int Q_BITS    = PROD_BITS - FRAC_BITS;

  // Configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = WORD_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [IDX_W-1:0]            idx_t;
  typedef logic [PROD_BITS-1:0]        prod_t;
  typedef logic [Q_BITS-1:0]           q_t;
  typedef logic [CFG_INDEX_BITS-1:0]   cfg_index_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  localparam cfg_index_t CFG_KICK_LENGTH = 2'd0;
  localparam cfg_index_t CFG_INV_RADIUS  = 2'd1;
  localparam cfg_index_t CFG_TOP_ORDER   = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TRACK = 1'b1;

  typedef struct packed {
    logic                  operation;
    logic [CIDX_BITS-1:0]  coef_index;
    logic signed [WORD_BITS-1:0] coef_normal;
    logic signed [WORD_BITS-1:0] coef_skew;
    logic signed [WORD_BITS-1:0] x;
    logic signed [WORD_BITS-1:0] px;
    logic signed [WORD_BITS-1:0] y;
    logic signed [WORD_BITS-1:0] py;
    logic signed [WORD_BITS-1:0] delta;
    logic signed [WORD_BITS-1:0] path;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] x_out;
    logic signed [WORD_BITS-1:0] px_out;
    logic signed [WORD_BITS-1:0] y_out;
    logic signed [WORD_BITS-1:0] py_out;
    logic signed [WORD_BITS-1:0] delta_out;
    logic signed [WORD_BITS-1:0] path_out;
    logic                        overflow;
  } out_item_t;

  // Multiplier operand selects
  typedef enum logic [2:0] {
    MOP_RE, MOP_IM, MOP_X, MOP_Y, MOP_H, MOP_L, MOP_TMP
  } mul_op_t;

  // Saturating adder sources and destinations
  typedef enum logic [3:0] {
    SRC_ZERO, SRC_PROD, SRC_TMP, SRC_ACC, SRC_RE, SRC_IM, SRC_COEF_N, SRC_COEF_S,
    SRC_DELTA, SRC_PX, SRC_PY, SRC_PATH
  } alu_src_t;

  typedef enum logic [2:0] {
    DST_TMP, DST_ACC, DST_RE, DST_IM, DST_PX, DST_PY, DST_PATH
  } alu_dst_t;

  typedef struct packed {
    logic     load_in;
    logic     coef_write;
    logic     rd_en;
    idx_t     rd_addr;
    logic     mul_start;
    mul_op_t  mul_a;
    mul_op_t  mul_b;
    logic     alu_en;
    alu_dst_t alu_dst;
    alu_src_t alu_a;
    alu_src_t alu_b;
    logic     alu_sub;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
  } dp_status_t;

endpackage

// ===== design/bend_multipole_thin_kick_unit.sv =====
// Top level of the bend multipole thin kick unit: configuration registers and wiring.
// Depends on bmtk_pkg, bmtk_ctrl and bmtk_datapath.
`timescale 1ns / 1ps

// Usage
//   item channel (item_valid / item_ready / item): one request per particle or per
//   coefficient write. operation = write stores coef_normal / coef_skew at coef_index
//   (indices past the table are dropped) and returns no result.
//   operation = track runs the field polynomial from order n = min(top_order, 15)
//   down to 0, then the kick, and returns one result on the result channel.
//   result channel (result_valid / result_ready / result): held until taken.
//   result_valid rises once a track has finished the kick; that result and the next
//   request can both be taken in the same cycle. Each order costs four products on
//   the single shared multiplier, each made of four half-width partial products plus
//   operand and rounding stages; the kick needs six more products.
//   A finished result sits in the output register, so the unit goes back to taking
//   requests while the receiver stalls; it only waits if a second result is ready
//   before the first is taken.
//   cfg port: kick_length, inv_radius, top_order, written while idle.
//   Reset (rst, synchronous) clears control state and the config registers; the
//   coefficient tables are not cleared and must be written before use.
module bend_multipole_thin_kick_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  bmtk_pkg::in_item_t            item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output bmtk_pkg::out_item_t           result,
  input  logic                          cfg_we,
  input  bmtk_pkg::cfg_index_t          cfg_index,
  input  logic [bmtk_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  // configuration registers
  bmtk_pkg::word_t                 kick_length;
  bmtk_pkg::word_t                 inv_radius;
  logic [bmtk_pkg::ORDER_BITS-1:0] top_order;

  bmtk_pkg::dp_cmd_t    cmd;
  bmtk_pkg::dp_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      kick_length <= '0;
      inv_radius  <= '0;
      top_order   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bmtk_pkg::CFG_KICK_LENGTH: kick_length <= cfg_data;
        bmtk_pkg::CFG_INV_RADIUS:  inv_radius  <= cfg_data;
        bmtk_pkg::CFG_TOP_ORDER:   top_order   <= cfg_data[bmtk_pkg::ORDER_BITS-1:0];
        default:                   top_order   <= top_order; // unused index
      endcase
    end
  end

  // sequencer: one item at a time, drives the datapath step by step
  bmtk_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_op      (item.operation),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .top_order    (top_order),
    .status       (status),
    .cmd          (cmd)
  );

  // coefficient RAM, shared multiplier, saturating adder, output register
  bmtk_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .item        (item),
    .kick_length (kick_length),
    .inv_radius  (inv_radius),
    .result      (result)
  );

endmodule

// ===== design/bmtk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bmtk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/bmtk_mul.sv =====
// Multi-cycle saturating fixed-point multiplier: four half-width partial products.
// Depends on bmtk_pkg.
`timescale 1ns / 1ps

module bmtk_mul (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bmtk_pkg::word_t a,
  input  bmtk_pkg::word_t b,
  output logic            done,
  output logic            sat,
  output bmtk_pkg::word_t result
);

  typedef enum logic [1:0] {P_IDLE, P_ACC, P_FIN} phase_t;

  localparam int H = bmtk_pkg::HALF_BITS;
  localparam int W = bmtk_pkg::WORD_BITS;

  phase_t phase;
  logic [2*H-1:0]        ma;
  logic [2*H-1:0]        mb;
  logic                  neg;
  bmtk_pkg::prod_t       acc;
  logic [1:0]            step;

  logic [H-1:0]          a_half;
  logic [H-1:0]          b_half;
  logic [2*H-1:0]        pp;
  bmtk_pkg::prod_t       pp_ext;
  bmtk_pkg::prod_t       pp_sh;
  bmtk_pkg::q_t          q;
  logic                  rem;
  bmtk_pkg::word_t       qw;
  logic                  fin_sat;
  bmtk_pkg::word_t       fin_val;

  function automatic logic [2*H-1:0] mag(input bmtk_pkg::word_t v);
    logic [W-1:0] m;
    m = v[W-1] ? (~v + 1'b1) : v;
    return (2*H)'(m);
  endfunction

  // partial product for the current step
  always_comb begin
    a_half = step[0] ? ma[2*H-1:H] : ma[H-1:0];
    b_half = step[1] ? mb[2*H-1:H] : mb[H-1:0];
    pp     = a_half * b_half;
    pp_ext = bmtk_pkg::prod_t'(pp);
    case (step)
      2'd0:    pp_sh = pp_ext;
      2'd3:    pp_sh = pp_ext << (2 * H);
      default: pp_sh = pp_ext << H;
    endcase
  end

  // truncation toward minus infinity and saturation
  always_comb begin
    q   = acc[bmtk_pkg::PROD_BITS-1:bmtk_pkg::FRAC_BITS];
    rem = |acc[bmtk_pkg::FRAC_BITS-1:0];
    qw  = q[W-1:0];
    if (!neg) begin
      fin_sat = q > bmtk_pkg::q_t'(bmtk_pkg::WORD_MAX);
      fin_val = fin_sat ? bmtk_pkg::WORD_MAX : qw;
    end else begin
      if (rem) begin
        fin_sat = q > bmtk_pkg::q_t'(bmtk_pkg::WORD_MAX);
      end else begin
        fin_sat = q > (bmtk_pkg::q_t'(bmtk_pkg::WORD_MAX) + 1'b1);
      end
      fin_val = fin_sat ? bmtk_pkg::WORD_MIN : (rem ? ~qw : (~qw + 1'b1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        P_IDLE: begin
          if (start) begin
            ma    <= mag(a);
            mb    <= mag(b);
            neg   <= a[W-1] ^ b[W-1];
            acc   <= '0;
            step  <= '0;
            phase <= P_ACC;
          end
        end
        P_ACC: begin
          acc  <= acc + pp_sh;
          step <= step + 2'd1;
          if (step == 2'd3) begin
            phase <= P_FIN;
          end
        end
        P_FIN: begin
          result <= fin_val;
          sat    <= fin_sat;
          done   <= 1'b1;
          phase  <= P_IDLE;
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  // a new operand pair is only issued to an idle unit
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (phase == P_IDLE))
    else $error("multiplier started while busy");

endmodule

// ===== design/bmtk_datapath.sv =====
// Datapath: coefficient RAM, particle registers, saturating adder and multiplier.
// Depends on bmtk_pkg, bmtk_ram and bmtk_mul.
`timescale 1ns / 1ps

module bmtk_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  bmtk_pkg::dp_cmd_t    cmd,
  output bmtk_pkg::dp_status_t status,
  input  bmtk_pkg::in_item_t   item,
  input  bmtk_pkg::word_t      kick_length,
  input  bmtk_pkg::word_t      inv_radius,
  output bmtk_pkg::out_item_t  result
);

  localparam int W = bmtk_pkg::WORD_BITS;

  bmtk_pkg::word_t x_r, px_r, y_r, py_r, delta_r, path_r;
  bmtk_pkg::word_t re, im, tmp, acc;
  logic            flag;

  logic [2*W-1:0]  coef_rd;
  bmtk_pkg::word_t coef_n, coef_s;
  logic            coef_we;

  bmtk_pkg::word_t mul_a, mul_b, prod;
  logic            mul_done, mul_sat;

  bmtk_pkg::word_t alu_a, alu_b, alu_res;
  logic [W:0]      alu_sum;
  logic            alu_sat;

  assign coef_we = cmd.coef_write && (int'(item.coef_index) < bmtk_pkg::TABLE_DEPTH);
  assign coef_n  = coef_rd[2*W-1:W];
  assign coef_s  = coef_rd[W-1:0];

  bmtk_ram #(
    .WIDTH (2 * W),
    .DEPTH (bmtk_pkg::TABLE_DEPTH)
  ) u_coef_ram (
    .clk     (clk),
    .wr_en   (coef_we),
    .wr_addr (bmtk_pkg::idx_t'(item.coef_index)),
    .wr_data ({item.coef_normal, item.coef_skew}),
    .rd_en   (cmd.rd_en),
    .rd_addr (cmd.rd_addr),
    .rd_data (coef_rd)
  );

  function automatic bmtk_pkg::word_t mul_sel(input bmtk_pkg::mul_op_t s,
      input bmtk_pkg::word_t re_v, input bmtk_pkg::word_t im_v,
      input bmtk_pkg::word_t x_v, input bmtk_pkg::word_t y_v,
      input bmtk_pkg::word_t h_v, input bmtk_pkg::word_t l_v,
      input bmtk_pkg::word_t t_v);
    bmtk_pkg::word_t v;
    case (s)
      bmtk_pkg::MOP_RE:  v = re_v;
      bmtk_pkg::MOP_IM:  v = im_v;
      bmtk_pkg::MOP_X:   v = x_v;
      bmtk_pkg::MOP_Y:   v = y_v;
      bmtk_pkg::MOP_H:   v = h_v;
      bmtk_pkg::MOP_L:   v = l_v;
      bmtk_pkg::MOP_TMP: v = t_v;
      default:           v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    mul_a = mul_sel(cmd.mul_a, re, im, x_r, y_r, inv_radius, kick_length, tmp);
    mul_b = mul_sel(cmd.mul_b, re, im, x_r, y_r, inv_radius, kick_length, tmp);
  end

  bmtk_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .sat    (mul_sat),
    .result (prod)
  );

  assign status.mul_done = mul_done;

  function automatic bmtk_pkg::word_t src_sel(input bmtk_pkg::alu_src_t s,
      input bmtk_pkg::word_t p_v, input bmtk_pkg::word_t t_v,
      input bmtk_pkg::word_t a_v, input bmtk_pkg::word_t re_v,
      input bmtk_pkg::word_t im_v, input bmtk_pkg::word_t cn_v,
      input bmtk_pkg::word_t cs_v, input bmtk_pkg::word_t d_v,
      input bmtk_pkg::word_t px_v, input bmtk_pkg::word_t py_v,
      input bmtk_pkg::word_t pa_v);
    bmtk_pkg::word_t v;
    case (s)
      bmtk_pkg::SRC_PROD:   v = p_v;
      bmtk_pkg::SRC_TMP:    v = t_v;
      bmtk_pkg::SRC_ACC:    v = a_v;
      bmtk_pkg::SRC_RE:     v = re_v;
      bmtk_pkg::SRC_IM:     v = im_v;
      bmtk_pkg::SRC_COEF_N: v = cn_v;
      bmtk_pkg::SRC_COEF_S: v = cs_v;
      bmtk_pkg::SRC_DELTA:  v = d_v;
      bmtk_pkg::SRC_PX:     v = px_v;
      bmtk_pkg::SRC_PY:     v = py_v;
      bmtk_pkg::SRC_PATH:   v = pa_v;
      default:              v = '0;
    endcase
    return v;
  endfunction

  // saturating add / subtract
  always_comb begin
    alu_a = src_sel(cmd.alu_a, prod, tmp, acc, re, im, coef_n, coef_s,
                    delta_r, px_r, py_r, path_r);
    alu_b = src_sel(cmd.alu_b, prod, tmp, acc, re, im, coef_n, coef_s,
                    delta_r, px_r, py_r, path_r);
    if (cmd.alu_sub) begin
      alu_sum = {alu_a[W-1], alu_a} - {alu_b[W-1], alu_b};
    end else begin
      alu_sum = {alu_a[W-1], alu_a} + {alu_b[W-1], alu_b};
    end
    alu_sat = alu_sum[W] ^ alu_sum[W-1];
    if (alu_sat) begin
      alu_res = alu_sum[W] ? bmtk_pkg::WORD_MIN : bmtk_pkg::WORD_MAX;
    end else begin
      alu_res = alu_sum[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r     <= item.x;
      px_r    <= item.px;
      y_r     <= item.y;
      py_r    <= item.py;
      delta_r <= item.delta;
      path_r  <= item.path;
      flag    <= 1'b0;
    end else begin
      flag <= flag | (cmd.alu_en & alu_sat) | (mul_done & mul_sat);
      if (cmd.alu_en) begin
        case (cmd.alu_dst)
          bmtk_pkg::DST_TMP:  tmp    <= alu_res;
          bmtk_pkg::DST_ACC:  acc    <= alu_res;
          bmtk_pkg::DST_RE:   re     <= alu_res;
          bmtk_pkg::DST_IM:   im     <= alu_res;
          bmtk_pkg::DST_PX:   px_r   <= alu_res;
          bmtk_pkg::DST_PY:   py_r   <= alu_res;
          bmtk_pkg::DST_PATH: path_r <= alu_res;
          default:            tmp    <= tmp;
        endcase
      end
    end
    if (cmd.out_load) begin
      result <= '{x_out: x_r, px_out: px_r, y_out: y_r, py_out: py_r,
                  delta_out: delta_r, path_out: path_r, overflow: flag};
    end
  end

endmodule

// ===== design/bmtk_ctrl.sv =====
// Controller: sequences the Horner evaluation and the final kick over the datapath.
// Depends on bmtk_pkg.
`timescale 1ns / 1ps

module bmtk_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  input  logic                        item_op,
  output logic                        item_ready,
  output logic                        result_valid,
  input  logic                        result_ready,
  input  logic [bmtk_pkg::ORDER_BITS-1:0] top_order,
  input  bmtk_pkg::dp_status_t        status,
  output bmtk_pkg::dp_cmd_t           cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_INIT2,
    S_H0, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_H7,
    S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7, S_F8, S_F9,
    S_DONE
  } state_t;

  state_t          state, state_next;
  bmtk_pkg::idx_t  cnt, cnt_next, order_clamped;
  logic            done;

  assign done       = status.mul_done;
  assign item_ready = (state == S_IDLE);

  always_comb begin
    if (int'(top_order) >= bmtk_pkg::TABLE_DEPTH) begin
      order_clamped = bmtk_pkg::idx_t'(bmtk_pkg::TABLE_DEPTH - 1);
    end else begin
      order_clamped = bmtk_pkg::idx_t'(top_order);
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          if (item_op == bmtk_pkg::OP_WRITE) begin
            cmd.coef_write = 1'b1;
          end else begin
            cmd.load_in = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = order_clamped;
            cnt_next    = order_clamped;
            state_next  = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.alu_en  = 1'b1;
        cmd.alu_dst = bmtk_pkg::DST_RE;
        cmd.alu_a   = bmtk_pkg::SRC_COEF_N;
        state_next  = S_INIT2;
      end
      S_INIT2: begin
        cmd.alu_en  = 1'b1;
        cmd.alu_dst = bmtk_pkg::DST_IM;
        cmd.alu_a   = bmtk_pkg::SRC_COEF_S;
        if (cnt == '0) begin
          state_next = S_F0;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = cnt - 1'b1;
          cnt_next    = cnt - 1'b1;
          state_next  = S_H0;
        end
      end
      // Horner step: re' = re*x - im*y + B, im' = im*x + re*y + A
      S_H0: begin
        cmd.mul_start = 1'b1;
        cmd.mul_a     = bmtk_pkg::MOP_RE;
        cmd.mul_b     = bmtk_pkg::MOP_X;
        state_next    = S_H1;
      end
      S_H1: begin
        if (done) begin
          cmd.alu_en    = 1'b1;
          cmd.alu_dst   = bmtk_pkg::DST_TMP;
          cmd.alu_a     = bmtk_pkg::SRC_PROD;
          cmd.mul_start = 1'b1;
          cmd.mul_a     = bmtk_pkg::MOP_IM;
          cmd.mul_b     = bmtk_pkg::MOP_Y;
          state_next    = S_H2;
        end
      end
      S_H2: begin
        if (done) begin
          cmd.alu_en    = 1'b1;
          cmd.alu_dst   = bmtk_pkg::DST_TMP;
          cmd.alu_a     = bmtk_pkg::SRC_TMP;
          cmd.alu_b     = bmtk_pkg::SRC_PROD;
          cmd.alu_sub   = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_a     = bmtk_pkg::MOP_IM;
          cmd.mul_b     = bmtk_pkg::MOP_X;
          state_next    = S_H3;
        end
      end
      S_H3: begin
        if (done) begin
          cmd.alu_en  = 1'b1;
          cmd.alu_dst = bmtk_pkg::DST_TMP;
          cmd.alu_a   = bmtk_pkg::SRC_TMP;
          cmd.alu_b   = bmtk_pkg::SRC_COEF_N;
          state_next  = S_H4;
        end
      end
      S_H4: begin
        cmd.alu_en    = 1'b1;
        cmd.alu_dst   = bmtk_pkg::DST_ACC;
        cmd.alu_a     = bmtk_pkg::SRC_PROD;
        cmd.mul_start = 1'b1;
        cmd.mul_a     = bmtk_pkg::MOP_RE;
        cmd.mul_b     = bmtk_pkg::MOP_Y;
        state_next    = S_H5;
      end
      S_H5: begin
        if (done) begin
          cmd.alu_en  = 1'b1;
          cmd.alu_dst = bmtk_pkg::DST_ACC;
          cmd.alu_a   = bmtk_pkg::SRC_ACC;
          cmd.alu_b   = bmtk_pkg::SRC_PROD;
          state_next  = S_H6;
        end
      end
      S_H6: begin
        cmd.alu_en  = 1'b1;
        cmd.alu_dst = bmtk_pkg::DST_IM;
        cmd.alu_a   = bmtk_pkg::SRC_ACC;
        cmd.alu_b   = bmtk_pkg::SRC_COEF_S;
        state_next  = S_H7;
      end
      S_H7: begin
        cmd.alu_en  = 1'b1;
        cmd.alu_dst = bmtk_pkg::DST_RE;
        cmd.alu_a   = bmtk_pkg::SRC_TMP;
        if (cnt == '0) begin
          state_next = S_F0;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = cnt - 1'b1;
          cnt_next    = cnt - 1'b1;
          state_next  = S_H0;
        end
      end
      // kick: t = (delta - x*h)*h, px -= L*(re - t), py += L*im, path += L*h*x
      S_F0: begin
        cmd.mul_start = 1'b1;
        cmd.mul_a     = bmtk_pkg::MOP_X;
        cmd.mul_b     = bmtk_pkg::MOP_H;
        state_next    = S_F1;
      end
      S_F1: begin
        if (done) begin
          cmd.alu_en  = 1'b1;
          cmd.alu_dst = bmtk_pkg::DST_TMP;
          cmd.alu_a   = bmtk_pkg::SRC_DELTA;
          cmd.alu_b   = bmtk_pkg::SRC_PROD;
          cmd.alu_sub = 1'b1;
          state_next  = S_F2;
        end
      end
      S_F2: begin
        cmd.mul_start = 1'b1;
        cmd.mul_a     = bmtk_pkg::MOP_TMP;
        cmd.mul_b     = bmtk_pkg::MOP_H;
        state_next    = S_F3;
      end
      S_F3: begin
        if (done) begin
          cmd.alu_en  = 1'b1;
          cmd.alu_dst = bmtk_pkg::DST_TMP;
          cmd.alu_a   = bmtk_pkg::SRC_RE;
          cmd.alu_b   = bmtk_pkg::SRC_PROD;
          cmd.alu_sub = 1'b1;
          state_next  = S_F4;
        end
      end
      S_F4: begin
        cmd.mul_start = 1'b1;
        cmd.mul_a     = bmtk_pkg::MOP_L;
        cmd.mul_b     = bmtk_pkg::MOP_TMP;
        state_next    = S_F5;
      end
      S_F5: begin
        if (done) begin
          cmd.alu_en    = 1'b1;
          cmd.alu_dst   = bmtk_pkg::DST_PX;
          cmd.alu_a     = bmtk_pkg::SRC_PX;
          cmd.alu_b     = bmtk_pkg::SRC_PROD;
          cmd.alu_sub   = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_a     = bmtk_pkg::MOP_L;
          cmd.mul_b     = bmtk_pkg::MOP_IM;
          state_next    = S_F6;
        end
      end
      S_F6: begin
        if (done) begin
          cmd.alu_en    = 1'b1;
          cmd.alu_dst   = bmtk_pkg::DST_PY;
          cmd.alu_a     = bmtk_pkg::SRC_PY;
          cmd.alu_b     = bmtk_pkg::SRC_PROD;
          cmd.mul_start = 1'b1;
          cmd.mul_a     = bmtk_pkg::MOP_L;
          cmd.mul_b     = bmtk_pkg::MOP_H;
          state_next    = S_F7;
        end
      end
      S_F7: begin
        if (done) begin
          cmd.alu_en  = 1'b1;
          cmd.alu_dst = bmtk_pkg::DST_TMP;
          cmd.alu_a   = bmtk_pkg::SRC_PROD;
          state_next  = S_F8;
        end
      end
      S_F8: begin
        cmd.mul_start = 1'b1;
        cmd.mul_a     = bmtk_pkg::MOP_TMP;
        cmd.mul_b     = bmtk_pkg::MOP_X;
        state_next    = S_F9;
      end
      S_F9: begin
        if (done) begin
          cmd.alu_en  = 1'b1;
          cmd.alu_dst = bmtk_pkg::DST_PATH;
          cmd.alu_a   = bmtk_pkg::SRC_PATH;
          cmd.alu_b   = bmtk_pkg::SRC_PROD;
          state_next  = S_DONE;
        end
      end
      S_DONE: begin
        if (!result_valid || result_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // the output register is never overwritten while it holds an untaken result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!result_valid || result_ready))
    else $error("result register overwritten");

  // a result only appears out of the final state
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_DONE))
    else $error("result raised outside final state");

endmodule
